// ----- src/swaf_pkg.sv -----
// shared types and constants for the sliding window anagram finder
// no dependencies; imported by every module of the block except swaf_ram
package swaf_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ALPHABET = 26;
  localparam int unsigned POS_W    = 32;

  // input kind codes as they arrive on the port
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } op_e;

  // one classified item waiting in the queue
  typedef struct packed {
    op_e                 op;
    logic [LETTER_W-1:0] letter;
  } entry_t;

  // work handed from the sequencer to the histogram stage
  typedef struct packed {
    logic                clr;
    logic                pat_inc;
    logic                txt;
    logic                rem;
    logic                chk;
    logic [LETTER_W-1:0] letter;
    logic [POS_W-1:0]    start;
  } work_t;

endpackage

// ----- src/swaf_ram.sv -----
// generic single write port ram with registered read, read-before-write
// no dependencies
module swaf_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/swaf_front.sv -----
// front end: accepts items, drops ignored ones, queues the rest (two entries)
// depends on swaf_pkg
module swaf_front
  import swaf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [LETTER_W-1:0] letter_i,
  output logic                q_valid_o,
  output entry_t              q_entry_o,
  input  logic                q_pop_i
);

  entry_t      slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        accept;
  logic        keep;
  logic        push;
  entry_t      entry;

  assign in_ready_o = (count_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry.letter = letter_i;
    entry.op     = OP_CLEAR;
    keep         = 1'b0;
    case (kind_i)
      KIND_CLEAR: begin
        keep = 1'b1;
      end
      KIND_PATTERN: begin
        entry.op = OP_PATTERN;
        keep     = (letter_i < LETTER_W'(ALPHABET));
      end
      KIND_TEXT: begin
        entry.op = OP_TEXT;
        keep     = (letter_i < LETTER_W'(ALPHABET));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= entry;
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_entry_o = slot_q[rd_ptr_q];

endmodule

// ----- src/swaf_seq.sv -----
// sequencer: pattern length, window fill, ring pointer, text position, ring memory
// depends on swaf_pkg and swaf_ram
module swaf_seq
  import swaf_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  entry_t              q_entry_i,
  output logic                q_pop_o,
  output logic                work_valid_o,
  output work_t               work_o,
  output logic [LETTER_W-1:0] oldest_o,
  input  logic                work_adv_i
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [CW-1:0] MaxLen  = CW'(MAX_PATTERN);
  localparam logic [CW:0]   MaxLenX = (CW+1)'(MAX_PATTERN);
  localparam logic [PW-1:0] LastPtr = PW'(MAX_PATTERN - 1);

  logic [CW-1:0]    plen_q, plen_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             work_valid_q, work_valid_d;
  work_t            work_q, work_d;
  logic             pop;
  logic             rem;
  logic             ring_we;
  logic [CW:0]      rp_x;
  logic [CW:0]      fill_x;
  logic [CW:0]      oldest_x;
  logic [PW-1:0]    oldest;

  assign pop = q_valid_i && (!work_valid_q || work_adv_i);

  // oldest window slot, ring index minus fill modulo the ring depth
  always_comb begin
    rp_x     = (CW+1)'(rp_q);
    fill_x   = (CW+1)'(fill_q);
    oldest_x = (rp_x >= fill_x) ? (rp_x - fill_x) : (rp_x + MaxLenX - fill_x);
    oldest   = oldest_x[PW-1:0];
  end

  always_comb begin
    plen_d  = plen_q;
    fill_d  = fill_q;
    rp_d    = rp_q;
    pos_d   = pos_q;
    work_d  = '0;
    ring_we = 1'b0;
    rem     = (fill_q == plen_q);
    work_d.letter = q_entry_i.letter;
    if (pop) begin
      case (q_entry_i.op)
        OP_CLEAR: begin
          plen_d     = '0;
          fill_d     = '0;
          rp_d       = '0;
          pos_d      = '0;
          work_d.clr = 1'b1;
        end
        OP_PATTERN: begin
          if (plen_q < MaxLen) begin
            plen_d         = plen_q + CW'(1);
            work_d.pat_inc = 1'b1;
          end
        end
        OP_TEXT: begin
          pos_d = pos_q + POS_W'(1);
          if (plen_q != '0) begin
            fill_d       = rem ? fill_q : fill_q + CW'(1);
            rp_d         = (rp_q == LastPtr) ? '0 : rp_q + PW'(1);
            ring_we      = 1'b1;
            work_d.txt   = 1'b1;
            work_d.rem   = rem;
            work_d.chk   = (fill_d == plen_q);
            work_d.start = pos_q - POS_W'(plen_q) + POS_W'(1);
          end
        end
        default: begin
          work_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      work_valid_d = 1'b1;
    end else if (work_adv_i) begin
      work_valid_d = 1'b0;
    end else begin
      work_valid_d = work_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q       <= '0;
      fill_q       <= '0;
      rp_q         <= '0;
      pos_q        <= '0;
      work_valid_q <= 1'b0;
    end else begin
      plen_q       <= plen_d;
      fill_q       <= fill_d;
      rp_q         <= rp_d;
      pos_q        <= pos_d;
      work_valid_q <= work_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      work_q <= work_d;
    end
  end

  swaf_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (rp_q),
    .wdata_i (q_entry_i.letter),
    .re_i    (pop),
    .raddr_i (oldest),
    .rdata_o (oldest_o)
  );

  assign q_pop_o      = pop;
  assign work_valid_o = work_valid_q;
  assign work_o       = work_q;

endmodule

// ----- src/swaf_hist.sv -----
// histogram stage: per-letter pattern and window counters, compare, result register
// depends on swaf_pkg
module swaf_hist
  import swaf_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                work_valid_i,
  input  work_t               work_i,
  input  logic [LETTER_W-1:0] oldest_i,
  output logic                work_adv_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [POS_W-1:0]    start_index_o
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

  logic [CW-1:0]    pat_q [ALPHABET];
  logic [CW-1:0]    pat_d [ALPHABET];
  logic [CW-1:0]    win_q [ALPHABET];
  logic [CW-1:0]    win_d [ALPHABET];
  logic [ALPHABET-1:0] equal;
  logic             match;
  logic             out_valid_q;
  logic [POS_W-1:0] start_q;

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      logic hit_new;
      logic hit_old;
      hit_new  = (work_i.letter == LETTER_W'(i));
      hit_old  = work_i.rem && (oldest_i == LETTER_W'(i)) && (win_q[i] != '0);
      pat_d[i] = pat_q[i];
      win_d[i] = win_q[i];
      if (work_i.clr) begin
        pat_d[i] = '0;
        win_d[i] = '0;
      end else if (work_i.pat_inc && hit_new) begin
        pat_d[i] = pat_q[i] + CW'(1);
      end else if (work_i.txt) begin
        case ({hit_new, hit_old})
          2'b10:   win_d[i] = win_q[i] + CW'(1);
          2'b01:   win_d[i] = win_q[i] - CW'(1);
          default: win_d[i] = win_q[i];
        endcase
      end
      equal[i] = (win_d[i] == pat_q[i]);
    end
  end

  assign match      = work_i.chk && (&equal);
  // a non-matching item never needs the result register
  assign work_adv_o = work_valid_i && (!out_valid_q || out_ready_i || !match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        pat_q[i] <= '0;
        win_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (work_adv_o) begin
        for (int i = 0; i < ALPHABET; i++) begin
          pat_q[i] <= pat_d[i];
          win_q[i] <= win_d[i];
        end
      end
      if (work_adv_o && match) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_adv_o && match) begin
      start_q <= work_i.start;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign start_index_o = start_q;

endmodule

// ----- src/sliding_window_anagram_finder.sv -----
// top level of the sliding window anagram finder
// depends on swaf_pkg, swaf_front, swaf_seq, swaf_hist (and swaf_ram below swaf_seq)
//
// usage
//   input channel (in_valid_i / in_ready_o) carries kind_i and letter_i:
//   clear session, pattern letter or text letter. the output channel
//   (out_valid_o / out_ready_i) carries start_index_o, the text position
//   where a window that is a permutation of the pattern begins.
//   items with kind 3, and pattern or text items with a letter past 'z',
//   are taken and dropped.
// throughput and path
//   one item per cycle sustained while no second match is held (see stalls).
//   a matching text letter passes the two-entry queue, where the sequencer
//   works on it (control counters, ring write and oldest-letter read), then
//   the sequencer's work register, read by the histogram stage (26 counter lanes
//   updated and compared in parallel), which then loads the output register.
// reset
//   everything empty: no pattern, empty window, position zero. the ring
//   memory is not cleared; only slots already written are ever used.
// stalls
//   a waiting result sits in the output register; items that do not match
//   keep flowing past it. a second match waits in the histogram stage, then
//   the queue fills and in_ready_o drops.
module sliding_window_anagram_finder
  import swaf_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [LETTER_W-1:0] letter_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [POS_W-1:0]    start_index_o
);

  // queue between front end and sequencer
  logic                q_valid;
  entry_t              q_entry;
  logic                q_pop;

  // sequencer to histogram stage
  logic                work_valid;
  work_t               work;
  logic [LETTER_W-1:0] oldest;
  logic                work_adv;

  swaf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .letter_i   (letter_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  swaf_seq #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .work_valid_o (work_valid),
    .work_o       (work),
    .oldest_o     (oldest),
    .work_adv_i   (work_adv)
  );

  swaf_hist #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_hist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .work_valid_i  (work_valid),
    .work_i        (work),
    .oldest_i      (oldest),
    .work_adv_o    (work_adv),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .start_index_o (start_index_o)
  );

endmodule
